[hw/rtl/fsas_pkg.sv]
// Shared types and constants for the feeder servo advance sequencer.
// Used by every module of the block; depends on nothing.
package fsas_pkg;

	// Request codes
	localparam logic [2:0] REQ_TICK    = 3'd0;
	localparam logic [2:0] REQ_ADVANCE = 3'd1;
	localparam logic [2:0] REQ_ENABLE  = 3'd2;
	localparam logic [2:0] REQ_DISABLE = 3'd3;
	localparam logic [2:0] REQ_RETRACT = 3'd4;

	// Motion state codes
	localparam logic [1:0] MODE_DISABLED = 2'd0;
	localparam logic [1:0] MODE_IDLE     = 2'd1;
	localparam logic [1:0] MODE_MOVING   = 2'd2;
	localparam logic [1:0] MODE_SETTLE   = 2'd3;

	// Feeder positions
	localparam logic [1:0] PLACE_RETRACT = 2'd0;
	localparam logic [1:0] PLACE_HALF    = 2'd1;
	localparam logic [1:0] PLACE_FULL    = 2'd2;

	// Servo output channel commands
	localparam logic [1:0] CHAN_NONE = 2'd0;
	localparam logic [1:0] CHAN_ON   = 2'd1;
	localparam logic [1:0] CHAN_OFF  = 2'd2;

	// Configuration register indexes
	localparam logic [2:0] REG_FULL_ANGLE = 3'd0;
	localparam logic [2:0] REG_HALF_ANGLE = 3'd1;
	localparam logic [2:0] REG_HOME_ANGLE = 3'd2;
	localparam logic [2:0] REG_RISE_SPEED = 3'd3;
	localparam logic [2:0] REG_FALL_SPEED = 3'd4;
	localparam logic [2:0] REG_SETTLE_MS  = 3'd5;
	localparam logic [2:0] REG_PULSE_MIN  = 3'd6;
	localparam logic [2:0] REG_PULSE_MAX  = 3'd7;

	// Feed length of one full advance, in mm
	localparam int ADVANCE_UNIT = 4;
	localparam logic [7:0] UNIT_LEN = 8'(ADVANCE_UNIT);
	localparam logic [7:0] HALF_LEN = 8'(ADVANCE_UNIT / 2);

	// Pulse width written on enable
	localparam logic [11:0] PULSE_ENABLE = 12'd310;
	localparam logic [11:0] PULSE_TOP    = 12'd4095;

	// Exact floor(n / 180) for n below 2**20: (n * RECIP_180) >> RECIP_SHIFT
	localparam int RECIP_SHIFT = 28;
	localparam logic [20:0] RECIP_180 = 21'((64'd1 << RECIP_SHIFT) / 180 + 1);

	typedef struct packed {
		logic [7:0]  full_angle;
		logic [7:0]  half_angle;
		logic [7:0]  home_angle;
		logic [15:0] rise_speed;
		logic [15:0] fall_speed;
		logic [15:0] settle_ms;
		logic [11:0] pulse_min;
		logic [11:0] pulse_max;
	} cfg_t;

	// Outcome of one sequencer step, before pulse mapping
	typedef struct packed {
		logic [7:0] deg;
		logic       upd;
		logic       pw_fix;
		logic [1:0] chan;
		logic       cyc;
		logic       ign;
		logic [1:0] mode;
	} step_res_t;

	// Load enables of the result pipeline
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic out;
	} stage_en_t;

endpackage

[hw/rtl/fsas_seq.sv]
// Sequencer state and single-step update: ramp, settle and advance walk.
// Depends on fsas_pkg.
module fsas_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  logic [2:0]            req_type,
	input  logic [7:0]            advance_len,
	input  fsas_pkg::cfg_t        cfg,
	output fsas_pkg::step_res_t   res
);

	logic [15:0] an_q, at_q, sc_q;
	logic [1:0]  place_q, mode_q;
	logic [7:0]  ll_q;
	logic        dp_q;

	logic [15:0] n_an, n_at, n_sc;
	logic [1:0]  n_place, n_mode;
	logic [7:0]  n_ll;
	logic        n_dp;

	logic [15:0] sc_inc, sc_chk, a_next, b_start, b_tgt, b_next;
	logic        a_chg, b_chg, a_used, b_used, chk, apply_adv, tick_mv;
	logic [7:0]  ll_in, adv_deg, adv_ll;
	logic [1:0]  adv_place;
	logic        adv_mv;
	logic [1:0]  chan;
	logic        cyc, ign, pw_fix;

	// One millisecond of ramp toward the target
	function automatic logic [15:0] servo_next(input logic [15:0] now, input logic [15:0] tgt,
			input logic [15:0] rise, input logic [15:0] fall);
		logic [15:0] diff;
		diff = 16'd0;
		servo_next = now;
		if (now < tgt) begin
			diff = tgt - now;
			servo_next = (rise != 16'd0 && diff > rise) ? now + rise : tgt;
		end else if (now > tgt) begin
			diff = now - tgt;
			servo_next = (fall != 16'd0 && diff > fall) ? now - fall : tgt;
		end
	endfunction

	// Integer angle before a step; zero compares as 255 so it rewrites unless the new angle is 255
	function automatic logic [7:0] prev_deg(input logic [15:0] ang);
		prev_deg = (ang[15:8] == 8'd0) ? 8'd255 : ang[15:8];
	endfunction

	always_comb begin
		// ramp of a running move
		sc_inc = (sc_q != 16'hFFFF) ? sc_q + 16'd1 : sc_q;
		a_next = servo_next(an_q, at_q, cfg.rise_speed, cfg.fall_speed);
		a_chg  = a_next[15:8] != prev_deg(an_q);

		// choose the next position of the advance walk
		ll_in     = (req_type == fsas_pkg::REQ_ADVANCE) ? advance_len : ll_q;
		adv_mv    = 1'b0;
		adv_deg   = cfg.home_angle;
		adv_place = place_q;
		adv_ll    = ll_in;
		unique case (place_q)
			fsas_pkg::PLACE_RETRACT: begin
				if (ll_in >= fsas_pkg::UNIT_LEN) begin
					adv_mv    = 1'b1;
					adv_deg   = cfg.full_angle;
					adv_place = fsas_pkg::PLACE_FULL;
					adv_ll    = ll_in - fsas_pkg::UNIT_LEN;
				end else if (ll_in >= fsas_pkg::HALF_LEN) begin
					adv_mv    = 1'b1;
					adv_deg   = cfg.half_angle;
					adv_place = fsas_pkg::PLACE_HALF;
					adv_ll    = ll_in - fsas_pkg::HALF_LEN;
				end
			end
			fsas_pkg::PLACE_HALF: begin
				if (ll_in >= fsas_pkg::HALF_LEN) begin
					adv_mv    = 1'b1;
					adv_deg   = cfg.full_angle;
					adv_place = fsas_pkg::PLACE_FULL;
					adv_ll    = ll_in - fsas_pkg::HALF_LEN;
				end
			end
			fsas_pkg::PLACE_FULL: begin
				adv_mv    = 1'b1;
				adv_place = fsas_pkg::PLACE_RETRACT;
			end
			default: ;
		endcase

		// first step of a new move; after a finished ramp it starts at the old target
		tick_mv = (req_type == fsas_pkg::REQ_TICK) && (mode_q == fsas_pkg::MODE_MOVING);
		b_start = tick_mv ? at_q : an_q;
		b_tgt   = {((req_type == fsas_pkg::REQ_RETRACT) ? cfg.home_angle : adv_deg), 8'd0};
		b_next  = servo_next(b_start, b_tgt, cfg.rise_speed, cfg.fall_speed);
		b_chg   = b_next[15:8] != prev_deg(b_start);

		n_an      = an_q;
		n_at      = at_q;
		n_sc      = sc_q;
		n_place   = place_q;
		n_mode    = mode_q;
		n_ll      = ll_q;
		n_dp      = dp_q;
		a_used    = 1'b0;
		b_used    = 1'b0;
		chk       = 1'b0;
		sc_chk    = sc_inc;
		apply_adv = 1'b0;
		chan      = fsas_pkg::CHAN_NONE;
		cyc       = 1'b0;
		ign       = 1'b0;
		pw_fix    = 1'b0;

		unique case (req_type)
			fsas_pkg::REQ_TICK: begin
				if (mode_q == fsas_pkg::MODE_MOVING) begin
					n_sc   = 16'd0;
					n_an   = a_next;
					a_used = 1'b1;
					if (a_next == at_q) begin
						n_mode = fsas_pkg::MODE_SETTLE;
						chk    = 1'b1;
						sc_chk = 16'd0;
					end
				end else if (mode_q != fsas_pkg::MODE_IDLE) begin
					n_sc = sc_inc;
					chk  = 1'b1;
				end
				// settle time elapsed: report a done cycle if one is owed, then idle or take the next step
				if (chk && sc_chk >= cfg.settle_ms) begin
					if (dp_q) begin
						n_dp = 1'b0;
						cyc  = 1'b1;
					end
					if (ll_q == 8'd0) begin
						if (mode_q != fsas_pkg::MODE_DISABLED) n_mode = fsas_pkg::MODE_IDLE;
					end else begin
						n_mode    = fsas_pkg::MODE_MOVING;
						apply_adv = 1'b1;
					end
				end
			end
			fsas_pkg::REQ_ADVANCE: begin
				if (advance_len != 8'd0) begin
					if (mode_q != fsas_pkg::MODE_IDLE) ign = 1'b1;
					else apply_adv = 1'b1;
				end
			end
			fsas_pkg::REQ_ENABLE: begin
				n_mode = fsas_pkg::MODE_IDLE;
				n_dp   = 1'b0;
				chan   = fsas_pkg::CHAN_ON;
				pw_fix = 1'b1;
			end
			fsas_pkg::REQ_DISABLE: begin
				n_mode = fsas_pkg::MODE_DISABLED;
				chan   = fsas_pkg::CHAN_OFF;
			end
			fsas_pkg::REQ_RETRACT: begin
				if (place_q == fsas_pkg::PLACE_FULL) begin
					n_at    = b_tgt;
					n_place = fsas_pkg::PLACE_RETRACT;
					n_mode  = fsas_pkg::MODE_MOVING;
					n_sc    = 16'd0;
					n_an    = b_next;
					b_used  = 1'b1;
				end
			end
			default: ;
		endcase

		// commit an advance step
		if (apply_adv) begin
			if (adv_mv) begin
				n_at    = b_tgt;
				n_place = adv_place;
				n_mode  = fsas_pkg::MODE_MOVING;
				n_sc    = 16'd0;
				n_an    = b_next;
				b_used  = 1'b1;
			end
			n_ll = adv_ll;
			if (adv_ll == 8'd0) n_dp = 1'b1;
		end

		// the later write of the step wins
		res.deg    = (b_used && b_chg) ? b_next[15:8] : a_next[15:8];
		res.upd    = (a_used && a_chg) || (b_used && b_chg);
		res.pw_fix = pw_fix;
		res.chan   = chan;
		res.cyc    = cyc;
		res.ign    = ign;
		res.mode   = n_mode;
	end

	// Advance sequencer state on each transfer out of the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			an_q    <= 16'd0;
			at_q    <= 16'd0;
			sc_q    <= 16'd0;
			place_q <= fsas_pkg::PLACE_RETRACT;
			mode_q  <= fsas_pkg::MODE_DISABLED;
			ll_q    <= 8'd0;
			dp_q    <= 1'b0;
		end else if (fire) begin
			an_q    <= n_an;
			at_q    <= n_at;
			sc_q    <= n_sc;
			place_q <= n_place;
			mode_q  <= n_mode;
			ll_q    <= n_ll;
			dp_q    <= n_dp;
		end
	end

endmodule

[hw/rtl/fsas_pulse.sv]
// Result pipeline: maps the integer angle onto the pulse range and saturates.
// Depends on fsas_pkg; stage loads are driven by the top level.
module fsas_pulse (
	input  logic                 clk,
	input  fsas_pkg::stage_en_t  en,
	input  fsas_pkg::step_res_t  res_in,
	input  fsas_pkg::cfg_t       cfg,
	output logic [11:0]          pulse_width,
	output logic                 pulse_update,
	output logic [1:0]           channel_cmd,
	output logic                 cycle_done,
	output logic                 advance_ignored,
	output logic [1:0]           motion_state
);

	localparam int QHI = fsas_pkg::RECIP_SHIFT + 12;

	fsas_pkg::step_res_t res_s2, res_s3, res_s4;
	logic [19:0] prod_s3;
	logic        neg_s3, neg_s4;
	logic [12:0] quot_s4;

	logic        span_neg;
	logic [11:0] span_mag;
	logic [19:0] prod;
	logic [40:0] wide;
	logic [14:0] sum;
	logic [11:0] sat;

	logic [11:0] pulse_width_q;
	logic        pulse_update_q, cycle_done_q, advance_ignored_q;
	logic [1:0]  channel_cmd_q, motion_state_q;

	always_comb begin
		// angle times span magnitude
		span_neg = cfg.pulse_max < cfg.pulse_min;
		span_mag = span_neg ? cfg.pulse_min - cfg.pulse_max : cfg.pulse_max - cfg.pulse_min;
		prod     = {12'd0, res_s2.deg} * {8'd0, span_mag};

		// divide by 180 through the reciprocal
		wide = {21'd0, prod_s3} * {20'd0, fsas_pkg::RECIP_180};

		// offset by pulse_min, truncating toward zero, then saturate
		sum = neg_s4 ? {3'd0, cfg.pulse_min} - {2'd0, quot_s4}
			: {3'd0, cfg.pulse_min} + {2'd0, quot_s4};
		if (sum[14]) sat = 12'd0;
		else if (sum[13:12] != 2'd0) sat = fsas_pkg::PULSE_TOP;
		else sat = sum[11:0];
	end

	// Stage registers; a stage loads only when the top lets it
	always_ff @(posedge clk) begin
		if (en.s2) res_s2 <= res_in;
		if (en.s3) begin
			res_s3  <= res_s2;
			prod_s3 <= prod;
			neg_s3  <= span_neg;
		end
		if (en.s4) begin
			res_s4  <= res_s3;
			quot_s4 <= wide[QHI:fsas_pkg::RECIP_SHIFT];
			neg_s4  <= neg_s3;
		end
		if (en.out) begin
			if (res_s4.pw_fix) pulse_width_q <= fsas_pkg::PULSE_ENABLE;
			else if (res_s4.upd) pulse_width_q <= sat;
			else pulse_width_q <= 12'd0;
			pulse_update_q    <= res_s4.upd || res_s4.pw_fix;
			channel_cmd_q     <= res_s4.chan;
			cycle_done_q      <= res_s4.cyc;
			advance_ignored_q <= res_s4.ign;
			motion_state_q    <= res_s4.mode;
		end
	end

	assign pulse_width     = pulse_width_q;
	assign pulse_update    = pulse_update_q;
	assign channel_cmd     = channel_cmd_q;
	assign cycle_done      = cycle_done_q;
	assign advance_ignored = advance_ignored_q;
	assign motion_state    = motion_state_q;

endmodule

[hw/rtl/feeder_servo_advance_sequencer_top.sv]
// Top level of the feeder servo advance sequencer: handshakes, configuration
// registers and pipeline control. Depends on fsas_pkg, fsas_seq and fsas_pulse.

// One request enters per clock while the pipeline is not held by a stalled output,
// and its single result is registered in the input register, updates the
// sequencer state and passes three stages of pulse mapping into the output
// register. The sustained rate is one item per cycle while the output moves on,
// set by the update of the sequencer state, which feeds straight back to the next
// request; the pulse multiply and the divide by 180 are pipelined behind it. A
// stalled output holds the pipeline one stage at a time, so empty stages keep
// taking requests. Configuration is written through its own port, which is
// always ready, and should only change while no request is in flight.
module feeder_servo_advance_sequencer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  req_type,
	input  logic [7:0]  advance_len,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [11:0] pulse_width,
	output logic        pulse_update,
	output logic [1:0]  channel_cmd,
	output logic        cycle_done,
	output logic        advance_ignored,
	output logic [1:0]  motion_state,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	fsas_pkg::cfg_t      cfg_q;
	fsas_pkg::step_res_t step_res;
	fsas_pkg::stage_en_t en;

	logic [2:0] req_s1;
	logic [7:0] len_s1;
	logic       v_s1, v_s2, v_s3, v_s4, out_valid_q;
	logic       en_s1, fire;

	// Stage enables: a stage loads when it is empty or its successor moves on
	always_comb begin
		en.out = !out_valid_q || out_ready;
		en.s4  = !v_s4 || en.out;
		en.s3  = !v_s3 || en.s4;
		en.s2  = !v_s2 || en.s3;
		en_s1  = !v_s1 || en.s2;
		fire   = v_s1 && en.s2;
	end

	assign in_ready  = en_s1;
	assign out_valid = out_valid_q;
	assign cfg_ready = 1'b1;

	// Advance stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3;
			if (en.out) out_valid_q <= v_s4;
		end
	end

	// Capture the request on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s1 <= fsas_pkg::REQ_TICK;
			len_s1 <= 8'd0;
		end else if (en_s1) begin
			req_s1 <= req_type;
			len_s1 <= advance_len;
		end
	end

	// Configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.full_angle <= 8'd80;
			cfg_q.half_angle <= 8'd40;
			cfg_q.home_angle <= 8'd0;
			cfg_q.rise_speed <= 16'd0;
			cfg_q.fall_speed <= 16'd0;
			cfg_q.settle_ms  <= 16'd240;
			cfg_q.pulse_min  <= 12'd100;
			cfg_q.pulse_max  <= 12'd500;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				fsas_pkg::REG_FULL_ANGLE: cfg_q.full_angle <= cfg_data[7:0];
				fsas_pkg::REG_HALF_ANGLE: cfg_q.half_angle <= cfg_data[7:0];
				fsas_pkg::REG_HOME_ANGLE: cfg_q.home_angle <= cfg_data[7:0];
				fsas_pkg::REG_RISE_SPEED: cfg_q.rise_speed <= cfg_data;
				fsas_pkg::REG_FALL_SPEED: cfg_q.fall_speed <= cfg_data;
				fsas_pkg::REG_SETTLE_MS:  cfg_q.settle_ms  <= cfg_data;
				fsas_pkg::REG_PULSE_MIN:  cfg_q.pulse_min  <= cfg_data[11:0];
				fsas_pkg::REG_PULSE_MAX:  cfg_q.pulse_max  <= cfg_data[11:0];
			endcase
		end
	end

	fsas_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.req_type    (req_s1),
		.advance_len (len_s1),
		.cfg         (cfg_q),
		.res         (step_res)
	);

	fsas_pulse u_pulse (
		.clk             (clk),
		.en              (en),
		.res_in          (step_res),
		.cfg             (cfg_q),
		.pulse_width     (pulse_width),
		.pulse_update    (pulse_update),
		.channel_cmd     (channel_cmd),
		.cycle_done      (cycle_done),
		.advance_ignored (advance_ignored),
		.motion_state    (motion_state)
	);

endmodule

[hw/rtl/fsas_checker.sv]
// Port-level checks for the feeder servo advance sequencer, bound to the top.
// Depends on fsas_pkg and feeder_servo_advance_sequencer_top.
module fsas_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [11:0] pulse_width,
	input logic        pulse_update,
	input logic [1:0]  channel_cmd,
	input logic        advance_ignored,
	input logic [1:0]  motion_state
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pulse_width) && $stable(motion_state))
		else $error("stalled result changed");

	// Enable turns the output on, writes the fixed width and idles
	a_enable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && channel_cmd == fsas_pkg::CHAN_ON |->
		pulse_update && pulse_width == fsas_pkg::PULSE_ENABLE &&
		motion_state == fsas_pkg::MODE_IDLE)
		else $error("enable result malformed");

	// Disable writes no pulse and leaves the block disabled
	a_disable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && channel_cmd == fsas_pkg::CHAN_OFF |->
		!pulse_update && motion_state == fsas_pkg::MODE_DISABLED)
		else $error("disable result malformed");

	// An ignored advance changes nothing and only arrives while busy or disabled
	a_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && advance_ignored |->
		!pulse_update && channel_cmd == fsas_pkg::CHAN_NONE &&
		motion_state != fsas_pkg::MODE_IDLE)
		else $error("ignored advance had side effects");

	// Drop the width to zero when nothing was written
	a_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pulse_update |-> pulse_width == 12'd0)
		else $error("pulse width without write");

endmodule

bind feeder_servo_advance_sequencer_top fsas_checker u_fsas_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.pulse_width     (pulse_width),
	.pulse_update    (pulse_update),
	.channel_cmd     (channel_cmd),
	.advance_ignored (advance_ignored),
	.motion_state    (motion_state)
);

[dv/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for feeder_servo_advance_sequencer_top.
// Holds its own servo sequencer predictor; depends on fsas_pkg and the block's RTL.
module tb_top;

	localparam int LIMIT_CYCLES = 1000000;
	localparam int PRINT_CAP = 20;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] len;
	} feeder_req_t;

	typedef struct packed {
		logic [11:0] pw;
		logic        upd;
		logic [1:0]  chan;
		logic        done;
		logic        ign;
		logic [1:0]  mode;
	} servo_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  req_type = '0;
	logic [7:0]  advance_len = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [11:0] pulse_width;
	logic        pulse_update;
	logic [1:0]  channel_cmd;
	logic        cycle_done;
	logic        advance_ignored;
	logic [1:0]  motion_state;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// Pending requests, expected servo outputs
	feeder_req_t feeder_req_q[$];
	servo_out_t  servo_out_q[$];
	feeder_req_t nxt_req;
	servo_out_t  want;

	logic quiet = 1'b0;
	logic hold_off = 1'b0;
	int   send_gap = 0;
	int   stall_left = 0;
	int   mismatches = 0;
	int   results_seen = 0;
	int   cycles = 0;

	// Predictor copy of configuration and sequencer state
	fsas_pkg::cfg_t cfg_m = '{full_angle: 8'd80, half_angle: 8'd40, home_angle: 8'd0,
		rise_speed: 16'd0, fall_speed: 16'd0, settle_ms: 16'd240,
		pulse_min: 12'd100, pulse_max: 12'd500};
	logic [15:0] ang_now = '0;
	logic [15:0] ang_goal = '0;
	logic [15:0] settle_cnt = '0;
	logic [1:0]  at_place = fsas_pkg::PLACE_RETRACT;
	logic [1:0]  seq_mode = fsas_pkg::MODE_DISABLED;
	logic [7:0]  feed_left = '0;
	logic        done_owed = 1'b0;
	logic [11:0] exp_pw;
	logic        exp_upd;
	logic        exp_cyc;

	feeder_servo_advance_sequencer_top DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.req_type        (req_type),
		.advance_len     (advance_len),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.pulse_width     (pulse_width),
		.pulse_update    (pulse_update),
		.channel_cmd     (channel_cmd),
		.cycle_done      (cycle_done),
		.advance_ignored (advance_ignored),
		.motion_state    (motion_state),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Linear map of integer degrees onto the pulse range, clamped to 12 bits
	function automatic logic [11:0] pulse_for(input int deg);
		int lo, span, v;
		lo = int'(cfg_m.pulse_min);
		span = int'(cfg_m.pulse_max) - lo;
		v = lo + (deg * span) / 180;
		if (v < 0) v = 0;
		if (v > int'(fsas_pkg::PULSE_TOP)) v = int'(fsas_pkg::PULSE_TOP);
		return 12'(v);
	endfunction

	// One millisecond of ramping; returns 1 while the target is not reached
	function automatic bit ramp_once();
		int was, now_deg;
		logic [15:0] d;
		was = int'(ang_now[15:8]);
		if (was == 0) was = 255;
		if (ang_now < ang_goal) begin
			d = ang_goal - ang_now;
			if (cfg_m.rise_speed != 0 && d > cfg_m.rise_speed) d = cfg_m.rise_speed;
			ang_now = ang_now + d;
		end else if (ang_now > ang_goal) begin
			d = ang_now - ang_goal;
			if (cfg_m.fall_speed != 0 && d > cfg_m.fall_speed) d = cfg_m.fall_speed;
			ang_now = ang_now - d;
		end
		now_deg = int'(ang_now[15:8]);
		if (now_deg != was) begin
			exp_pw = pulse_for(now_deg);
			exp_upd = 1'b1;
		end
		return ang_now != ang_goal;
	endfunction

	function automatic void begin_move(input logic [7:0] deg, input logic [1:0] pos);
		ang_goal = {deg, 8'h00};
		at_place = pos;
		seq_mode = fsas_pkg::MODE_MOVING;
		settle_cnt = '0;
		void'(ramp_once());
	endfunction

	// Walk to the next position of the feed cycle
	function automatic void step_place();
		if (at_place == fsas_pkg::PLACE_RETRACT) begin
			if (feed_left >= fsas_pkg::UNIT_LEN) begin
				begin_move(cfg_m.full_angle, fsas_pkg::PLACE_FULL);
				feed_left = feed_left - fsas_pkg::UNIT_LEN;
			end else if (feed_left >= fsas_pkg::HALF_LEN) begin
				begin_move(cfg_m.half_angle, fsas_pkg::PLACE_HALF);
				feed_left = feed_left - fsas_pkg::HALF_LEN;
			end
		end else if (at_place == fsas_pkg::PLACE_HALF) begin
			if (feed_left >= fsas_pkg::HALF_LEN) begin
				begin_move(cfg_m.full_angle, fsas_pkg::PLACE_FULL);
				feed_left = feed_left - fsas_pkg::HALF_LEN;
			end
		end else if (at_place == fsas_pkg::PLACE_FULL) begin
			begin_move(cfg_m.home_angle, fsas_pkg::PLACE_RETRACT);
		end
		if (feed_left == 0) done_owed = 1'b1;
	endfunction

	// After the settle time: flag completion, go idle or take the next step
	function automatic void check_settled();
		if (settle_cnt < cfg_m.settle_ms) return;
		if (done_owed) begin
			done_owed = 1'b0;
			exp_cyc = 1'b1;
		end
		if (feed_left == 0) begin
			if (seq_mode != fsas_pkg::MODE_DISABLED) seq_mode = fsas_pkg::MODE_IDLE;
			return;
		end
		seq_mode = fsas_pkg::MODE_MOVING;
		step_place();
	endfunction

	function automatic servo_out_t servo_predict(input logic [2:0] kind, input logic [7:0] len);
		servo_out_t r;
		r = '0;
		exp_pw = '0;
		exp_upd = 1'b0;
		exp_cyc = 1'b0;
		case (kind)
			fsas_pkg::REQ_TICK: begin
				if (seq_mode == fsas_pkg::MODE_MOVING) begin
					settle_cnt = '0;
					if (!ramp_once()) begin
						seq_mode = fsas_pkg::MODE_SETTLE;
						check_settled();
					end
				end else if (seq_mode != fsas_pkg::MODE_IDLE) begin
					if (settle_cnt != 16'hFFFF) settle_cnt = settle_cnt + 16'd1;
					check_settled();
				end
			end
			fsas_pkg::REQ_ADVANCE: begin
				if (len != 0) begin
					if (seq_mode != fsas_pkg::MODE_IDLE) begin
						r.ign = 1'b1;
					end else begin
						feed_left = len;
						step_place();
					end
				end
			end
			fsas_pkg::REQ_ENABLE: begin
				seq_mode = fsas_pkg::MODE_IDLE;
				done_owed = 1'b0;
				r.chan = fsas_pkg::CHAN_ON;
				exp_pw = fsas_pkg::PULSE_ENABLE;
				exp_upd = 1'b1;
			end
			fsas_pkg::REQ_DISABLE: begin
				seq_mode = fsas_pkg::MODE_DISABLED;
				r.chan = fsas_pkg::CHAN_OFF;
			end
			fsas_pkg::REQ_RETRACT: begin
				if (at_place == fsas_pkg::PLACE_FULL)
					begin_move(cfg_m.home_angle, fsas_pkg::PLACE_RETRACT);
			end
			default: begin
			end
		endcase
		r.pw = exp_pw;
		r.upd = exp_upd;
		r.done = exp_cyc;
		r.mode = seq_mode;
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input logic [15:0] got,
		input logic [15:0] exp_val);
		if (mismatches < PRINT_CAP)
			$display("mismatch at result %0d: %s got %0d expected %0d",
				results_seen, what, got, exp_val);
		mismatches++;
	endtask

	// Mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Request driver: predict on each transfer, then offer the next request
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				servo_out_q.push_back(servo_predict(req_type, advance_len));
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (feeder_req_q.size() > 0) begin
					nxt_req = feeder_req_q.pop_front();
					in_valid <= 1'b1;
					req_type <= nxt_req.kind;
					advance_len <= nxt_req.len;
					send_gap = quiet ? 0 : pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compare each transfer with the oldest expectation
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (servo_out_q.size() == 0) begin
					flag_mismatch("unexpected result", {4'd0, pulse_width}, 16'd0);
				end else begin
					want = servo_out_q.pop_front();
					if (pulse_width !== want.pw)
						flag_mismatch("pulse_width", {4'd0, pulse_width}, {4'd0, want.pw});
					if (pulse_update !== want.upd)
						flag_mismatch("pulse_update", {15'd0, pulse_update}, {15'd0, want.upd});
					if (channel_cmd !== want.chan)
						flag_mismatch("channel_cmd", {14'd0, channel_cmd}, {14'd0, want.chan});
					if (cycle_done !== want.done)
						flag_mismatch("cycle_done", {15'd0, cycle_done}, {15'd0, want.done});
					if (advance_ignored !== want.ign)
						flag_mismatch("advance_ignored", {15'd0, advance_ignored},
							{15'd0, want.ign});
					if (motion_state !== want.mode)
						flag_mismatch("motion_state", {14'd0, motion_state}, {14'd0, want.mode});
				end
				results_seen++;
			end
			if (hold_off) begin
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!quiet && $urandom_range(0, 3) == 0) stall_left = pick_gap();
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic void queue_req(input logic [2:0] kind, input logic [7:0] len);
		feeder_req_q.push_back('{kind: kind, len: len});
	endfunction

	// Write one register and mirror it into the predictor once transferred
	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			fsas_pkg::REG_FULL_ANGLE: cfg_m.full_angle = val[7:0];
			fsas_pkg::REG_HALF_ANGLE: cfg_m.half_angle = val[7:0];
			fsas_pkg::REG_HOME_ANGLE: cfg_m.home_angle = val[7:0];
			fsas_pkg::REG_RISE_SPEED: cfg_m.rise_speed = val;
			fsas_pkg::REG_FALL_SPEED: cfg_m.fall_speed = val;
			fsas_pkg::REG_SETTLE_MS: cfg_m.settle_ms = val;
			fsas_pkg::REG_PULSE_MIN: cfg_m.pulse_min = val[11:0];
			fsas_pkg::REG_PULSE_MAX: cfg_m.pulse_max = val[11:0];
			default: begin
			end
		endcase
	endtask

	task automatic load_settings(input fsas_pkg::cfg_t s);
		write_reg(fsas_pkg::REG_FULL_ANGLE, 16'(s.full_angle));
		write_reg(fsas_pkg::REG_HALF_ANGLE, 16'(s.half_angle));
		write_reg(fsas_pkg::REG_HOME_ANGLE, 16'(s.home_angle));
		write_reg(fsas_pkg::REG_RISE_SPEED, s.rise_speed);
		write_reg(fsas_pkg::REG_FALL_SPEED, s.fall_speed);
		write_reg(fsas_pkg::REG_SETTLE_MS, s.settle_ms);
		write_reg(fsas_pkg::REG_PULSE_MIN, 16'(s.pulse_min));
		write_reg(fsas_pkg::REG_PULSE_MAX, 16'(s.pulse_max));
	endtask

	// Hold until every request is transferred and every result checked
	task automatic wait_drain();
		do @(negedge clk);
		while (feeder_req_q.size() != 0 || in_valid || servo_out_q.size() != 0);
	endtask

	// Mostly whole feed cycles with random content, plus disables and noise
	task automatic queue_traffic(input int n, input int tick_hi);
		int made, r, k;
		logic [2:0] kind;
		made = 0;
		while (made < n) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				if ($urandom_range(0, 3) == 0) begin
					queue_req(fsas_pkg::REQ_ENABLE, 8'($urandom));
					made++;
				end
				if ($urandom_range(0, 7) == 0)
					queue_req(fsas_pkg::REQ_ADVANCE, 8'($urandom_range(0, 255)));
				else
					queue_req(fsas_pkg::REQ_ADVANCE, 8'($urandom_range(1, 12)));
				k = $urandom_range(1, tick_hi);
				repeat (k) begin
					if ($urandom_range(0, 19) == 0)
						queue_req(fsas_pkg::REQ_RETRACT, 8'($urandom));
					else
						queue_req(fsas_pkg::REQ_TICK, 8'($urandom));
				end
				made += k + 1;
			end else if (r < 80) begin
				k = $urandom_range(1, tick_hi);
				repeat (k) queue_req(fsas_pkg::REQ_TICK, 8'($urandom));
				made += k;
			end else if (r < 88) begin
				queue_req(fsas_pkg::REQ_DISABLE, 8'($urandom));
				k = $urandom_range(0, tick_hi / 2);
				repeat (k) queue_req(fsas_pkg::REQ_TICK, 8'($urandom));
				queue_req(fsas_pkg::REQ_ENABLE, 8'($urandom));
				made += k + 2;
			end else begin
				kind = 3'($urandom_range(0, 7));
				queue_req(kind, 8'($urandom));
				if (kind <= fsas_pkg::REQ_RETRACT) made++;
			end
		end
	endtask

	initial begin
		fsas_pkg::cfg_t s;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset settings with a short settle time
		write_reg(fsas_pkg::REG_SETTLE_MS, 16'd1);
		queue_req(fsas_pkg::REQ_TICK, 8'h00);
		queue_req(3'd5, 8'hFF);
		queue_req(3'd6, 8'h55);
		queue_req(3'd7, 8'hAA);
		queue_req(fsas_pkg::REQ_ADVANCE, 8'd8);
		queue_req(fsas_pkg::REQ_RETRACT, 8'h00);
		queue_req(fsas_pkg::REQ_DISABLE, 8'h00);
		queue_req(fsas_pkg::REQ_ENABLE, 8'h00);
		queue_req(fsas_pkg::REQ_ADVANCE, 8'd0);
		// leftover below half a unit keeps the block cycling
		queue_req(fsas_pkg::REQ_ADVANCE, 8'd3);
		repeat (3) queue_req(fsas_pkg::REQ_TICK, 8'h00);
		queue_req(fsas_pkg::REQ_ADVANCE, 8'd9);
		// enable while moving freezes the motion
		queue_req(fsas_pkg::REQ_ENABLE, 8'h00);
		queue_req(fsas_pkg::REQ_ADVANCE, 8'd4);
		queue_req(fsas_pkg::REQ_RETRACT, 8'h00);
		queue_req(fsas_pkg::REQ_TICK, 8'h00);
		// disable while busy, settle time still counts
		queue_req(fsas_pkg::REQ_DISABLE, 8'h00);
		repeat (3) queue_req(fsas_pkg::REQ_TICK, 8'h00);
		queue_req(fsas_pkg::REQ_ENABLE, 8'h00);
		queue_req(fsas_pkg::REQ_ADVANCE, 8'd255);
		repeat (2) queue_req(fsas_pkg::REQ_TICK, 8'hFF);
		wait_drain();

		// Immediate jumps, short settle
		s.full_angle = 8'($urandom_range(60, 180));
		s.half_angle = 8'($urandom_range(20, 90));
		s.home_angle = 8'($urandom_range(0, 20));
		s.rise_speed = 16'd0;
		s.fall_speed = 16'd0;
		s.settle_ms = 16'($urandom_range(0, 3));
		s.pulse_min = 12'($urandom_range(0, 1000));
		s.pulse_max = 12'($urandom_range(1000, 4095));
		load_settings(s);
		queue_traffic(250, 30);
		wait_drain();

		// Ramped motion
		s.full_angle = 8'($urandom_range(60, 180));
		s.half_angle = 8'($urandom_range(20, 90));
		s.home_angle = 8'($urandom_range(0, 20));
		s.rise_speed = 16'($urandom_range(16'h0180, 16'h0800));
		s.fall_speed = 16'($urandom_range(16'h0200, 16'h0C00));
		s.settle_ms = 16'($urandom_range(1, 4));
		s.pulse_min = 12'($urandom_range(0, 4095));
		s.pulse_max = 12'($urandom_range(0, 4095));
		load_settings(s);
		queue_traffic(300, 120);
		wait_drain();

		// Upper extremes, inverted pulse range clamps at zero
		s.full_angle = 8'd255;
		s.half_angle = 8'd255;
		s.home_angle = 8'd180;
		s.rise_speed = 16'hFFFF;
		s.fall_speed = 16'hFFFF;
		s.settle_ms = 16'd0;
		s.pulse_min = 12'd4095;
		s.pulse_max = 12'd0;
		load_settings(s);
		queue_traffic(200, 30);
		wait_drain();

		// Lower extremes: every position at angle zero
		s.full_angle = 8'd0;
		s.half_angle = 8'd0;
		s.home_angle = 8'd0;
		s.rise_speed = 16'd0;
		s.fall_speed = 16'd0;
		s.settle_ms = 16'd0;
		s.pulse_min = 12'd0;
		s.pulse_max = 12'd0;
		load_settings(s);
		queue_traffic(150, 20);
		wait_drain();

		// Out-of-range angles with back-pressure: no idling, long receiver hold
		s.full_angle = 8'($urandom_range(200, 255));
		s.half_angle = 8'($urandom_range(181, 255));
		s.home_angle = 8'($urandom_range(0, 30));
		s.rise_speed = 16'($urandom_range(16'h0300, 16'h2000));
		s.fall_speed = 16'($urandom_range(16'h0300, 16'h2000));
		s.settle_ms = 16'($urandom_range(0, 2));
		s.pulse_min = 12'd0;
		s.pulse_max = 12'd4095;
		load_settings(s);
		quiet <= 1'b1;
		queue_traffic(300, 60);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (400) @(posedge clk);
		hold_off <= 1'b0;
		wait_drain();
		@(posedge clk);
		quiet <= 1'b0;

		// Longest settle time: motion ends but never settles
		s.rise_speed = 16'($urandom_range(16'h0100, 16'h4000));
		s.fall_speed = 16'($urandom_range(16'h0100, 16'h4000));
		s.settle_ms = 16'hFFFF;
		load_settings(s);
		queue_traffic(120, 40);
		wait_drain();

		// Fully random settings with a short settle
		s.full_angle = 8'($urandom);
		s.half_angle = 8'($urandom);
		s.home_angle = 8'($urandom);
		s.rise_speed = 16'($urandom);
		s.fall_speed = 16'($urandom);
		s.settle_ms = 16'($urandom_range(0, 6));
		s.pulse_min = 12'($urandom);
		s.pulse_max = 12'($urandom);
		load_settings(s);
		queue_traffic(230, 40);
		wait_drain();

		repeat (20) @(posedge clk);
		if (servo_out_q.size() != 0)
			flag_mismatch("results never arrived", 16'(servo_out_q.size()), 16'd0);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
